// ----- src/estm_pkg.sv -----
package estm_pkg;

    typedef logic signed [33:0] t_q30;

    typedef struct packed {
        logic               func;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] col0_row0;
        logic signed [31:0] col0_row1;
        logic signed [31:0] col0_row2;
        logic signed [31:0] col1_row0;
        logic signed [31:0] col1_row1;
        logic signed [31:0] col1_row2;
        logic signed [31:0] col2_row0;
        logic signed [31:0] col2_row1;
        logic signed [31:0] col2_row2;
        logic signed [31:0] out_shift_x;
        logic signed [31:0] out_shift_y;
        logic signed [31:0] out_shift_z;
    } t_out;

    localparam int CORDIC_STEPS = 24;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int QUO_BITS = 36;
    localparam int DIV_PER_STAGE = QUO_BITS / CORDIC_STAGES;
    localparam int DIVIDEND_BIT = 33;
    localparam t_q30 CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [67:0] Q30_HALF = 68'sd536870912;
    localparam logic signed [31:0] POS_FULL = 32'sh7FFFFFFF;
    localparam logic signed [31:0] NEG_FULL = 32'sh80000000;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    function automatic t_q30 atan34(logic [4:0] idx);
        return t_q30'(ATAN_TAB[idx]);
    endfunction

    function automatic t_q30 mq30(t_q30 a, t_q30 b);
        logic signed [67:0] p;
        p = a * b;
        p = p + Q30_HALF;
        return p[63:30];
    endfunction

    function automatic logic signed [31:0] scale_sat(t_q30 r, logic signed [31:0] f);
        logic signed [67:0] p;
        logic signed [37:0] s;
        p = r * t_q30'(f);
        p = p + Q30_HALF;
        s = p[67:30];
        if (s > 38'sd2147483647) begin
            return POS_FULL;
        end else if (s < -38'sd2147483648) begin
            return NEG_FULL;
        end else begin
            return s[31:0];
        end
    endfunction

    function automatic logic [23:0] mag24(logic signed [23:0] s);
        return s[23] ? 24'(-s) : s;
    endfunction

    function automatic logic signed [31:0] recip_fin(logic [35:0] q, logic neg, logic zero);
        logic [35:0] qr;
        qr = (q + 36'd1) >> 1;
        if (zero) begin
            return POS_FULL;
        end else if (!neg) begin
            return (qr > 36'h07FFFFFFF) ? POS_FULL : qr[31:0];
        end else begin
            return (qr > 36'h080000000) ? NEG_FULL : 32'(32'd0 - qr[31:0]);
        end
    endfunction

endpackage

// ----- src/euler_scale_transform_matrix_unit.sv -----
// Builds a scaled Euler YXZ rotation matrix plus translation for each input beat.
// Input channel: i_valid, o_stall, i_data. A beat is taken at a clock edge with
// i_valid high and o_stall low. Output channel: o_valid, i_stall, o_data, taken
// when o_valid is high and i_stall is low.
// func 0 scales column k of the rotation by scale k and passes the translation;
// func 1 scales by the reciprocal of each scale and drives a zero translation.
// The pipeline has 16 register stages: one fold stage that takes the beat,
// twelve CORDIC stages (two rotation steps and three quotient bits of the
// reciprocal divider per stage, three angle lanes and three divider lanes side
// by side), two matrix product stages and the output register. One beat enters
// every cycle while o_stall is low.
// While the output holds a beat and i_stall is high, the whole pipeline
// freezes and o_stall is raised; nothing is dropped or repeated.
// Reset clears all stage valid bits; the first beat can enter on the next cycle.
module euler_scale_transform_matrix_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  estm_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output estm_pkg::t_out  o_data
);

    localparam int NCS = estm_pkg::CORDIC_STAGES;

    logic en;

    logic             r_vld [0:NCS];
    estm_pkg::t_in    r_in  [0:NCS];
    estm_pkg::t_q30   r_x   [0:NCS][0:2];
    estm_pkg::t_q30   r_y   [0:NCS][0:2];
    estm_pkg::t_q30   r_z   [0:NCS][0:2];
    logic             r_neg [0:NCS][0:2];
    logic [23:0]      r_rem [0:NCS][0:2];
    logic [35:0]      r_quo [0:NCS][0:2];

    logic             r1_vld;
    estm_pkg::t_in    r1_in;
    estm_pkg::t_q30   r1_s12, r1_c1c3, r1_c1s2, r1_c3s1, r1_c1s3, r1_s1s3;
    estm_pkg::t_q30   r1_r1, r1_r4, r1_r6, r1_r7, r1_r8, r1_s2, r1_s3, r1_c3;
    logic signed [31:0] r1_f [0:2];

    logic             r2_vld;
    estm_pkg::t_in    r2_in;
    estm_pkg::t_q30   r2_r [0:8];
    logic signed [31:0] r2_f [0:2];

    logic             r_out_vld;
    estm_pkg::t_out   r_out;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Fold each angle into [-pi/2, pi/2] and load the CORDIC and divider lanes.
    estm_pkg::t_q30 n0_z   [0:2];
    logic           n0_neg [0:2];

    always_comb begin
        logic signed [16:0] a;
        logic signed [15:0] ang [0:2];
        ang[0] = i_data.angle_y;
        ang[1] = i_data.angle_x;
        ang[2] = i_data.angle_z;
        for (int l = 0; l < 3; l++) begin
            a = 17'(ang[l]);
            n0_neg[l] = 1'b0;
            if (a > 17'sd16384) begin
                a = a - 17'sd32768;
                n0_neg[l] = 1'b1;
            end else if (a < -17'sd16384) begin
                a = a + 17'sd32768;
                n0_neg[l] = 1'b1;
            end
            n0_z[l] = estm_pkg::t_q30'($signed({a, 16'd0}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NCS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NCS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r1_vld    <= r_vld[NCS];
            r2_vld    <= r1_vld;
            r_out_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in[0] <= i_data;
            for (int l = 0; l < 3; l++) begin
                r_x[0][l]   <= estm_pkg::CORDIC_GAIN;
                r_y[0][l]   <= '0;
                r_z[0][l]   <= n0_z[l];
                r_neg[0][l] <= n0_neg[l];
                r_rem[0][l] <= '0;
                r_quo[0][l] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= NCS; k++) begin : g_cs
        localparam int STEP0 = estm_pkg::STEPS_PER_STAGE * (k - 1);
        localparam int BIT0  = estm_pkg::QUO_BITS - 1 - estm_pkg::DIV_PER_STAGE * (k - 1);

        estm_pkg::t_q30 n_x [0:2];
        estm_pkg::t_q30 n_y [0:2];
        estm_pkg::t_q30 n_z [0:2];
        logic [23:0]    n_rem [0:2];
        logic [35:0]    n_quo [0:2];

        always_comb begin
            estm_pkg::t_q30 x, y, z, dx, dy;
            logic [24:0] rs;
            logic [23:0] m;
            logic signed [23:0] sc [0:2];
            sc[0] = r_in[k-1].scale_x;
            sc[1] = r_in[k-1].scale_y;
            sc[2] = r_in[k-1].scale_z;
            for (int l = 0; l < 3; l++) begin
                x = r_x[k-1][l];
                y = r_y[k-1][l];
                z = r_z[k-1][l];
                for (int j = 0; j < estm_pkg::STEPS_PER_STAGE; j++) begin
                    dx = y >>> (STEP0 + j);
                    dy = x >>> (STEP0 + j);
                    if (!z[33]) begin
                        x = x - dx;
                        y = y + dy;
                        z = z - estm_pkg::atan34(5'(STEP0 + j));
                    end else begin
                        x = x + dx;
                        y = y - dy;
                        z = z + estm_pkg::atan34(5'(STEP0 + j));
                    end
                end
                n_x[l] = x;
                n_y[l] = y;
                n_z[l] = z;

                m        = estm_pkg::mag24(sc[l]);
                n_rem[l] = r_rem[k-1][l];
                n_quo[l] = r_quo[k-1][l];
                for (int j = 0; j < estm_pkg::DIV_PER_STAGE; j++) begin
                    rs = {n_rem[l], (BIT0 - j == estm_pkg::DIVIDEND_BIT)};
                    if (rs >= {1'b0, m}) begin
                        n_rem[l] = 24'(rs - {1'b0, m});
                        n_quo[l] = {n_quo[l][34:0], 1'b1};
                    end else begin
                        n_rem[l] = rs[23:0];
                        n_quo[l] = {n_quo[l][34:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_in[k] <= r_in[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_x[k][l]   <= n_x[l];
                    r_y[k][l]   <= n_y[l];
                    r_z[k][l]   <= n_z[l];
                    r_neg[k][l] <= r_neg[k-1][l];
                    r_rem[k][l] <= n_rem[l];
                    r_quo[k][l] <= n_quo[l];
                end
            end
        end
    end

    // First product stage: sines, cosines and the scale factors.
    estm_pkg::t_q30     s [0:2];
    estm_pkg::t_q30     c [0:2];
    logic signed [31:0] n1_f [0:2];

    always_comb begin
        logic signed [23:0] sc [0:2];
        sc[0] = r_in[NCS].scale_x;
        sc[1] = r_in[NCS].scale_y;
        sc[2] = r_in[NCS].scale_z;
        for (int l = 0; l < 3; l++) begin
            s[l] = r_neg[NCS][l] ? -r_y[NCS][l] : r_y[NCS][l];
            c[l] = r_neg[NCS][l] ? -r_x[NCS][l] : r_x[NCS][l];
            if (r_in[NCS].func) begin
                n1_f[l] = estm_pkg::recip_fin(r_quo[NCS][l], sc[l][23], sc[l] == 24'sd0);
            end else begin
                n1_f[l] = 32'(sc[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_in   <= r_in[NCS];
            r1_s12  <= estm_pkg::mq30(s[0], s[1]);
            r1_c1c3 <= estm_pkg::mq30(c[0], c[2]);
            r1_c1s2 <= estm_pkg::mq30(c[0], s[1]);
            r1_c3s1 <= estm_pkg::mq30(c[2], s[0]);
            r1_c1s3 <= estm_pkg::mq30(c[0], s[2]);
            r1_s1s3 <= estm_pkg::mq30(s[0], s[2]);
            r1_r1   <= estm_pkg::mq30(c[1], s[2]);
            r1_r4   <= estm_pkg::mq30(c[1], c[2]);
            r1_r6   <= estm_pkg::mq30(c[1], s[0]);
            r1_r7   <= -s[1];
            r1_r8   <= estm_pkg::mq30(c[0], c[1]);
            r1_s2   <= s[1];
            r1_s3   <= s[2];
            r1_c3   <= c[2];
            for (int l = 0; l < 3; l++) begin
                r1_f[l] <= n1_f[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_in   <= r1_in;
            r2_r[0] <= r1_c1c3 + estm_pkg::mq30(r1_s12, r1_s3);
            r2_r[1] <= r1_r1;
            r2_r[2] <= estm_pkg::mq30(r1_c1s2, r1_s3) - r1_c3s1;
            r2_r[3] <= estm_pkg::mq30(r1_s12, r1_c3) - r1_c1s3;
            r2_r[4] <= r1_r4;
            r2_r[5] <= estm_pkg::mq30(r1_c1c3, r1_s2) + r1_s1s3;
            r2_r[6] <= r1_r6;
            r2_r[7] <= r1_r7;
            r2_r[8] <= r1_r8;
            for (int l = 0; l < 3; l++) begin
                r2_f[l] <= r1_f[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.col0_row0   <= estm_pkg::scale_sat(r2_r[0], r2_f[0]);
            r_out.col0_row1   <= estm_pkg::scale_sat(r2_r[1], r2_f[0]);
            r_out.col0_row2   <= estm_pkg::scale_sat(r2_r[2], r2_f[0]);
            r_out.col1_row0   <= estm_pkg::scale_sat(r2_r[3], r2_f[1]);
            r_out.col1_row1   <= estm_pkg::scale_sat(r2_r[4], r2_f[1]);
            r_out.col1_row2   <= estm_pkg::scale_sat(r2_r[5], r2_f[1]);
            r_out.col2_row0   <= estm_pkg::scale_sat(r2_r[6], r2_f[2]);
            r_out.col2_row1   <= estm_pkg::scale_sat(r2_r[7], r2_f[2]);
            r_out.col2_row2   <= estm_pkg::scale_sat(r2_r[8], r2_f[2]);
            r_out.out_shift_x <= r2_in.func ? 32'sd0 : r2_in.shift_x;
            r_out.out_shift_y <= r2_in.func ? 32'sd0 : r2_in.shift_y;
            r_out.out_shift_z <= r2_in.func ? 32'sd0 : r2_in.shift_z;
        end
    end

endmodule

// ----- src/estm_checker.sv -----
module estm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input estm_pkg::t_out  o_data
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow a held output beat");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed or vanished");

endmodule

bind euler_scale_transform_matrix_unit estm_checker u_estm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
